[src/lc3ie_pkg.sv]
// Shared types, constants and helper functions for the LC-3 instruction executor.
// No dependencies.
`default_nettype none
package lc3ie_pkg;

  localparam logic [15:0] KBSR_ADDR = 16'hFE00;
  localparam logic [15:0] KBDR_ADDR = 16'hFE02;
  localparam logic [15:0] PC_RESET  = 16'h3000;
  localparam logic [15:0] KEY_FLAG  = 16'h8000;
  localparam logic [15:0] CLEAR_LAST = 16'hFFFF;

  localparam logic [7:0] VEC_GETC = 8'h20;
  localparam logic [7:0] VEC_IN   = 8'h23;
  localparam logic [7:0] VEC_HALT = 8'h25;

  localparam logic [2:0] FLAGS_N = 3'd4;
  localparam logic [2:0] FLAGS_Z = 3'd2;
  localparam logic [2:0] FLAGS_P = 3'd1;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_EXEC  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALTED  = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_HOST    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_BR   = 4'd0,
    OP_ADD  = 4'd1,
    OP_LD   = 4'd2,
    OP_ST   = 4'd3,
    OP_JSR  = 4'd4,
    OP_AND  = 4'd5,
    OP_LDR  = 4'd6,
    OP_STR  = 4'd7,
    OP_RTI  = 4'd8,
    OP_NOT  = 4'd9,
    OP_LDI  = 4'd10,
    OP_STI  = 4'd11,
    OP_JMP  = 4'd12,
    OP_RES  = 4'd13,
    OP_LEA  = 4'd14,
    OP_TRAP = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    SEL_MEM  = 2'd0,
    SEL_KBSR = 2'd1,
    SEL_KBDR = 2'd2
  } rsel_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HREAD, S_F1, S_F2, S_F3,
    S_LDW, S_LDI1, S_STI1, S_TRP, S_DONE
  } state_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v == 16'd0) begin
      return FLAGS_Z;
    end else if (v[15]) begin
      return FLAGS_N;
    end else begin
      return FLAGS_P;
    end
  endfunction

endpackage
`default_nettype wire

[src/lc3ie_mem.sv]
// Single-port 64K x 16 synchronous main memory with registered read data.
// Depends on nothing but the clock.
`default_nettype none
module lc3ie_mem (
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [15:0] addr,
  input  wire logic [15:0] wdata,
  output logic      [15:0] rdata
);

  logic [15:0] mem [65536];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[src/lc3_instruction_executor_core.sv]
// LC-3 core: a host write goes from idle to done, a host read via HREAD, an
// instruction via F1, F2, F3 (LDI longest; an illegal opcode ends after F1,
// execute while halted goes straight to done), as set by the single main
// memory port and the one-port register file. One beat is worked on at a
// time; the result register lets the next beat enter while a result waits.
// Reset (rst, synchronous) starts a clearing pass over all 65536 main memory
// words and the register file; no beat is accepted during it.
`default_nettype none
module lc3_instruction_executor_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              func,
  input  wire logic [15:0]             addr,
  input  wire logic [15:0]             data,
  input  wire logic                    key_ready,
  input  wire logic [7:0]              key_char,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [1:0]                   status,
  output logic [15:0]                  pc_value,
  output logic [7:0]                   trap_vector,
  output logic [15:0]                  r0_value,
  output logic [15:0]                  read_data
);
  import lc3ie_pkg::*;

  // Architectural state. The keyboard status and data words live in their
  // own registers so that a core read of the status word can update both
  // without spending memory cycles.
  state_t      state, state_next;
  logic [15:0] pc, pc_next;
  logic [2:0]  flags, flags_next;
  logic        halted, halted_next;
  logic [15:0] kbsr, kbsr_next;
  logic [15:0] kbdr, kbdr_next;
  logic [15:0] r0, r0_next;
  logic [15:0] clr, clr_next;

  // Per-beat working registers.
  logic [15:0] ins, ins_next;
  logic [15:0] opa, opa_next;
  logic [15:0] opb, opb_next;
  logic        kr, kr_next;
  logic [7:0]  kc, kc_next;
  rsel_t       rsel, rsel_next;
  logic [1:0]  st_r, st_r_next;
  logic [7:0]  vec_r, vec_r_next;
  logic [15:0] rd_r, rd_r_next;
  logic        out_valid_next;

  // Main memory port.
  logic        mem_we;
  logic [15:0] mem_addr, mem_wd, mem_q;

  lc3ie_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wd),
    .rdata (mem_q)
  );

  // Register file: one port, registered read data.
  logic [15:0] rf [8];
  logic        rf_we;
  logic [2:0]  rf_addr;
  logic [15:0] rf_wd, rf_q;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_addr] <= rf_wd;
    end
    rf_q <= rf[rf_addr];
  end

  // Generic access requests raised by the sequencer and resolved below it.
  logic        rd_en, rd_core, wr_en, lat_en;
  logic [15:0] rd_addr, wr_addr, wr_data;
  logic [15:0] rdata, ins_w, pcoff, baseoff, bval, alu;
  opcode_t     op, op_w;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    pc_next = pc;
    flags_next = flags;
    halted_next = halted;
    kbsr_next = kbsr;
    kbdr_next = kbdr;
    r0_next = r0;
    clr_next = clr;
    ins_next = ins;
    opa_next = opa;
    opb_next = opb;
    kr_next = kr;
    kc_next = kc;
    rsel_next = rsel;
    st_r_next = st_r;
    vec_r_next = vec_r;
    rd_r_next = rd_r;
    out_valid_next = out_valid & out_stall;

    rd_en = 1'b0;
    rd_core = 1'b0;
    rd_addr = pc;
    wr_en = 1'b0;
    wr_addr = pc;
    wr_data = opb;
    lat_en = 1'b0;
    mem_we = 1'b0;
    mem_addr = pc;
    mem_wd = opb;
    rf_we = 1'b0;
    rf_addr = 3'd0;
    rf_wd = opb;

    // Data returned by the read issued in the previous cycle.
    case (rsel)
      SEL_KBSR: rdata = kbsr;
      SEL_KBDR: rdata = kbdr;
      default:  rdata = mem_q;
    endcase

    op      = opcode_t'(ins[15:12]);
    pcoff   = pc + {{7{ins[8]}}, ins[8:0]};
    baseoff = opa + {{10{ins[5]}}, ins[5:0]};
    bval    = ins[5] ? {{11{ins[4]}}, ins[4:0]} : rf_q;
    // A fetch at the keyboard status address sees the key state of this beat.
    ins_w   = (pc == KBSR_ADDR) ? (kr ? KEY_FLAG : 16'd0) : rdata;
    op_w    = opcode_t'(ins_w[15:12]);
    alu     = 16'd0;

    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr;
        mem_wd = 16'd0;
        rf_we = 1'b1;
        rf_addr = clr[2:0];
        rf_wd = 16'd0;
        clr_next = clr + 16'd1;
        if (clr == CLEAR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kr_next = key_ready;
          kc_next = key_char;
          st_r_next = halted ? ST_HALTED : ST_OK;
          vec_r_next = 8'd0;
          rd_r_next = 16'd0;
          state_next = S_DONE;
          case (func_t'(func))
            FUNC_WRITE: begin
              wr_en = 1'b1;
              wr_addr = addr;
              wr_data = data;
            end
            FUNC_READ: begin
              rd_en = 1'b1;
              rd_addr = addr;
              state_next = S_HREAD;
            end
            FUNC_EXEC: begin
              if (!halted) begin
                rd_en = 1'b1;
                rd_addr = pc;
                state_next = S_F1;
              end
            end
            default: ;
          endcase
        end
      end
      S_HREAD: begin
        rd_r_next = rdata;
        state_next = S_DONE;
      end
      S_F1: begin
        if (op_w == OP_RTI || op_w == OP_RES) begin
          st_r_next = ST_ILLEGAL;
          state_next = S_DONE;
        end else begin
          lat_en = (pc == KBSR_ADDR);
          pc_next = pc + 16'd1;
          ins_next = ins_w;
          rf_addr = ins_w[8:6];
          state_next = S_F2;
        end
      end
      S_F2: begin
        opa_next = rf_q;
        if (op == OP_ST || op == OP_STI || op == OP_STR) begin
          rf_addr = ins[11:9];
        end else begin
          rf_addr = ins[2:0];
        end
        state_next = S_F3;
      end
      S_F3: begin
        state_next = S_DONE;
        opb_next = rf_q;
        case (op)
          OP_BR: begin
            if ((ins[11:9] & flags) != 3'd0) begin
              pc_next = pcoff;
            end
          end
          OP_ADD, OP_AND, OP_NOT: begin
            if (op == OP_ADD) begin
              alu = opa + bval;
            end else if (op == OP_AND) begin
              alu = opa & bval;
            end else begin
              alu = ~opa;
            end
            rf_we = 1'b1;
            rf_addr = ins[11:9];
            rf_wd = alu;
            flags_next = flags_of(alu);
          end
          OP_LD, OP_LDR, OP_LDI: begin
            rd_en = 1'b1;
            rd_core = 1'b1;
            rd_addr = (op == OP_LDR) ? baseoff : pcoff;
            state_next = (op == OP_LDI) ? S_LDI1 : S_LDW;
          end
          OP_LEA: begin
            rf_we = 1'b1;
            rf_addr = ins[11:9];
            rf_wd = pcoff;
            flags_next = flags_of(pcoff);
          end
          OP_ST, OP_STR: begin
            wr_en = 1'b1;
            wr_addr = (op == OP_STR) ? baseoff : pcoff;
            wr_data = rf_q;
          end
          OP_STI: begin
            rd_en = 1'b1;
            rd_core = 1'b1;
            rd_addr = pcoff;
            state_next = S_STI1;
          end
          OP_JMP: begin
            pc_next = opa;
          end
          OP_JSR: begin
            // The target uses the base register as read before R7 changes.
            rf_we = 1'b1;
            rf_addr = 3'd7;
            rf_wd = pc;
            pc_next = ins[11] ? (pc + {{5{ins[10]}}, ins[10:0]}) : opa;
          end
          OP_TRAP: begin
            rf_we = 1'b1;
            rf_addr = 3'd7;
            rf_wd = pc;
            vec_r_next = ins[7:0];
            if (ins[7:0] == VEC_GETC || ins[7:0] == VEC_IN) begin
              state_next = S_TRP;
            end else if (ins[7:0] == VEC_HALT) begin
              halted_next = 1'b1;
              st_r_next = ST_HALTED;
            end else begin
              st_r_next = ST_HOST;
            end
          end
          default: ;
        endcase
      end
      S_LDW: begin
        rf_we = 1'b1;
        rf_addr = ins[11:9];
        rf_wd = rdata;
        flags_next = flags_of(rdata);
        state_next = S_DONE;
      end
      S_LDI1: begin
        rd_en = 1'b1;
        rd_core = 1'b1;
        rd_addr = rdata;
        state_next = S_LDW;
      end
      S_STI1: begin
        wr_en = 1'b1;
        wr_addr = rdata;
        wr_data = opb;
        state_next = S_DONE;
      end
      S_TRP: begin
        rf_we = 1'b1;
        rf_addr = 3'd0;
        rf_wd = {8'd0, kc};
        flags_next = flags_of({8'd0, kc});
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Resolve reads: the keyboard words are served from their registers.
    if (rd_en) begin
      mem_addr = rd_addr;
      if (rd_addr == KBSR_ADDR) begin
        rsel_next = SEL_KBSR;
        lat_en = lat_en | rd_core;
      end else if (rd_addr == KBDR_ADDR) begin
        rsel_next = SEL_KBDR;
      end else begin
        rsel_next = SEL_MEM;
      end
    end

    // A core read of the status word latches this beat's key fields.
    if (lat_en) begin
      kbsr_next = kr ? KEY_FLAG : 16'd0;
      if (kr) begin
        kbdr_next = {8'd0, kc};
      end
    end

    if (wr_en) begin
      if (wr_addr == KBSR_ADDR) begin
        kbsr_next = wr_data;
      end else if (wr_addr == KBDR_ADDR) begin
        kbdr_next = wr_data;
      end else begin
        mem_we = 1'b1;
        mem_addr = wr_addr;
        mem_wd = wr_data;
      end
    end

    // R0 is mirrored so that every result can report it.
    if (rf_we && rf_addr == 3'd0) begin
      r0_next = rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pc <= PC_RESET;
      flags <= FLAGS_Z;
      halted <= 1'b0;
      kbsr <= 16'd0;
      kbdr <= 16'd0;
      r0 <= 16'd0;
      clr <= 16'd0;
      out_valid <= 1'b0;
      rsel <= SEL_MEM;
    end else begin
      state <= state_next;
      pc <= pc_next;
      flags <= flags_next;
      halted <= halted_next;
      kbsr <= kbsr_next;
      kbdr <= kbdr_next;
      r0 <= r0_next;
      clr <= clr_next;
      out_valid <= out_valid_next;
      rsel <= rsel_next;
    end
  end

  always_ff @(posedge clk) begin
    ins <= ins_next;
    opa <= opa_next;
    opb <= opb_next;
    kr <= kr_next;
    kc <= kc_next;
    st_r <= st_r_next;
    vec_r <= vec_r_next;
    rd_r <= rd_r_next;
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status <= st_r;
      pc_value <= pc;
      trap_vector <= vec_r;
      r0_value <= r0;
      read_data <= rd_r;
    end
  end

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the LC-3 instruction executor core: host loads,
// host reads and single-instruction execution, checked against a shadow core.
// Depends on src/lc3ie_pkg.sv and src/lc3_instruction_executor_core.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lc3ie_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [15:0] data;
    logic        key_ready;
    logic [7:0]  key_char;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pc_value;
    logic [7:0]  trap_vector;
    logic [15:0] r0_value;
    logic [15:0] read_data;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = '0;
  logic [15:0] addr = '0;
  logic [15:0] data = '0;
  logic        key_ready = 1'b0;
  logic [7:0]  key_char = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  status;
  logic [15:0] pc_value;
  logic [7:0]  trap_vector;
  logic [15:0] r0_value;
  logic [15:0] read_data;

  always #5 clk = ~clk;

  lc3_instruction_executor_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .addr(addr), .data(data),
    .key_ready(key_ready), .key_char(key_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .pc_value(pc_value), .trap_vector(trap_vector),
    .r0_value(r0_value), .read_data(read_data)
  );

  // Shadow copy of the core's architectural state.
  logic [15:0] shadow_mem [0:65535];
  logic [15:0] shadow_regs [0:7];
  logic [15:0] shadow_pc;
  logic [2:0]  shadow_flags;
  logic        shadow_halted;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   error_count = 0;
  bit   long_hold = 0;

  function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
    logic [15:0] mask;
    mask = 16'((32'd1 << bits) - 1);
    v = v & mask;
    if (v[bits-1]) v = v | ~mask;
    return v;
  endfunction

  function automatic logic [2:0] nzp_of(input logic [15:0] v);
    if (v == 16'd0) return FLAGS_Z;
    if (v[15]) return FLAGS_N;
    return FLAGS_P;
  endfunction

  // Every core-side read of the keyboard status word refreshes the latch.
  function automatic logic [15:0] core_load(input logic [15:0] a, input cmd_t c);
    if (a == KBSR_ADDR) begin
      if (c.key_ready) begin
        shadow_mem[KBSR_ADDR] = KEY_FLAG;
        shadow_mem[KBDR_ADDR] = {8'd0, c.key_char};
      end else begin
        shadow_mem[KBSR_ADDR] = 16'd0;
      end
    end
    return shadow_mem[a];
  endfunction

  function automatic logic [1:0] run_instruction(input cmd_t c, output logic [7:0] vec);
    logic [15:0] ins, pc, pcoff, baseoff, b, t, dummy;
    logic [3:0]  op;
    logic [2:0]  dr, sr1;
    logic [1:0]  st;
    st = ST_OK;
    vec = 8'd0;
    pc = shadow_pc;
    // The fetch itself sees the freshly latched status word.
    if (pc == KBSR_ADDR) ins = c.key_ready ? KEY_FLAG : 16'd0;
    else ins = shadow_mem[pc];
    op = ins[15:12];
    if (op == OP_RTI || op == OP_RES) return ST_ILLEGAL;
    dummy = core_load(pc, c);
    pc = pc + 16'd1;
    shadow_pc = pc;
    dr = ins[11:9];
    sr1 = ins[8:6];
    pcoff = pc + sext(ins, 9);
    baseoff = shadow_regs[sr1] + sext(ins, 6);
    b = ins[5] ? sext(ins, 5) : shadow_regs[ins[2:0]];
    case (opcode_t'(op))
      OP_BR:  if ((dr & shadow_flags) != 0) shadow_pc = pcoff;
      OP_ADD: begin
        shadow_regs[dr] = shadow_regs[sr1] + b;
        shadow_flags = nzp_of(shadow_regs[dr]);
      end
      OP_AND: begin
        shadow_regs[dr] = shadow_regs[sr1] & b;
        shadow_flags = nzp_of(shadow_regs[dr]);
      end
      OP_NOT: begin
        shadow_regs[dr] = ~shadow_regs[sr1];
        shadow_flags = nzp_of(shadow_regs[dr]);
      end
      OP_LD: begin
        shadow_regs[dr] = core_load(pcoff, c);
        shadow_flags = nzp_of(shadow_regs[dr]);
      end
      OP_LDI: begin
        t = core_load(pcoff, c);
        shadow_regs[dr] = core_load(t, c);
        shadow_flags = nzp_of(shadow_regs[dr]);
      end
      OP_LDR: begin
        shadow_regs[dr] = core_load(baseoff, c);
        shadow_flags = nzp_of(shadow_regs[dr]);
      end
      OP_LEA: begin
        shadow_regs[dr] = pcoff;
        shadow_flags = nzp_of(pcoff);
      end
      OP_ST:  shadow_mem[pcoff] = shadow_regs[dr];
      OP_STI: begin
        t = core_load(pcoff, c);
        shadow_mem[t] = shadow_regs[dr];
      end
      OP_STR: shadow_mem[baseoff] = shadow_regs[dr];
      OP_JMP: shadow_pc = shadow_regs[sr1];
      OP_JSR: begin
        // JSRR through R7 must use the old R7, so the target is taken first.
        t = ins[11] ? pc + sext(ins, 11) : shadow_regs[sr1];
        shadow_regs[7] = pc;
        shadow_pc = t;
      end
      default: begin
        shadow_regs[7] = pc;
        vec = ins[7:0];
        if (vec == VEC_GETC || vec == VEC_IN) begin
          shadow_regs[0] = {8'd0, c.key_char};
          shadow_flags = nzp_of(shadow_regs[0]);
        end else if (vec == VEC_HALT) begin
          shadow_halted = 1'b1;
          st = ST_HALTED;
        end else begin
          st = ST_HOST;
        end
      end
    endcase
    return st;
  endfunction

  function automatic res_t predict_beat(input cmd_t c);
    res_t r;
    logic [7:0] vec;
    r = '0;
    r.status = shadow_halted ? ST_HALTED : ST_OK;
    if (c.func == FUNC_WRITE) shadow_mem[c.addr] = c.data;
    else if (c.func == FUNC_READ) r.read_data = shadow_mem[c.addr];
    else if (c.func == FUNC_EXEC && !shadow_halted) begin
      r.status = run_instruction(c, vec);
      r.trap_vector = vec;
    end
    r.pc_value = shadow_pc;
    r.r0_value = shadow_regs[0];
    return r;
  endfunction

  // Random gap: mostly zero or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  bit   accepted_last = 0;
  int   idle_cycles = 0;

  // Driver: present the next beat at the falling edge, hold it while stalled.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted_last) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          func <= c.func;
          addr <= c.addr;
          data <= c.data;
          key_ready <= c.key_ready;
          key_char <= c.key_char;
          send_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Acceptance sampled at the rising edge; the predictor runs at that point.
  always @(posedge clk) begin
    accepted_last <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_beat(
          '{func, addr, data, key_ready, key_char}));
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, actual status=%0d pc=%h",
                   $realtime, status, pc_value);
          error_count++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (e.status !== status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, status);
            error_count++;
          end
          if (e.pc_value !== pc_value) begin
            $display("%0t: pc_value expected %h actual %h", $realtime, e.pc_value, pc_value);
            error_count++;
          end
          if (e.trap_vector !== trap_vector) begin
            $display("%0t: trap_vector expected %h actual %h", $realtime, e.trap_vector,
                     trap_vector);
            error_count++;
          end
          if (e.r0_value !== r0_value) begin
            $display("%0t: r0_value expected %h actual %h", $realtime, e.r0_value, r0_value);
            error_count++;
          end
          if (e.read_data !== read_data) begin
            $display("%0t: read_data expected %h actual %h", $realtime, e.read_data,
                     read_data);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the core backs up.
  int stall_left = 0;
  always @(negedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog; no beats move during the reset clearing pass, so the idle limit allows for it.
  always @(posedge clk) begin
    if (idle_cycles > 300000) begin
      $display("[lc3_instruction_executor_core] ERROR");
      $finish;
    end
  end

  task automatic add_cmd(input logic [1:0] f, input logic [15:0] a, input logic [15:0] d,
                         input logic kr, input logic [7:0] kc);
    cmd_t c;
    c.func = f;
    c.addr = a;
    c.data = d;
    c.key_ready = kr;
    c.key_char = kc;
    pending_cmds.push_back(c);
  endtask

  task automatic add_exec();
    add_cmd(FUNC_EXEC, 16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // Random instruction word biased towards useful offsets and traps.
  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    int p;
    w = 16'($urandom);
    p = $urandom_range(0, 19);
    if (p == 0) w = {OP_TRAP, 4'd0, VEC_HALT};
    else if (p < 3) w = {OP_TRAP, 4'd0, ($urandom_range(0, 1) ? VEC_GETC : VEC_IN)};
    else if (p < 4) w = {OP_TRAP, 4'd0, 8'($urandom)};
    else if (p < 6) w[15:12] = OP_BR;
    else if (p < 8) w = {OP_LD, w[11:9], 9'h1FF}; // offset -1 reads the LD word itself
    return w;
  endfunction

  // One program: load a few words at the PC's neighborhood, then step through.
  task automatic add_program(input logic [15:0] base);
    int n, i;
    logic [15:0] w;
    n = $urandom_range(3, 10);
    for (i = 0; i < n; i++) begin
      w = rand_instr();
      if (w[15:12] == OP_RTI || w[15:12] == OP_RES) w[15:12] = OP_ADD;
      add_cmd(FUNC_WRITE, base + 16'(i), w, 1'b0, 8'd0);
    end
    if ($urandom_range(0, 3) == 0) add_cmd(FUNC_WRITE, KBSR_ADDR, 16'($urandom), 1'b0, 8'd0);
    for (i = 0; i < n; i++) begin
      add_exec();
      if ($urandom_range(0, 7) == 0)
        add_cmd(FUNC_READ, base + 16'($urandom_range(0, 15)), 16'($urandom), 1'b0, 8'd0);
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < 65536; i++) shadow_mem[i] = 16'd0;
    for (i = 0; i < 8; i++) shadow_regs[i] = 16'd0;
    shadow_pc = PC_RESET;
    shadow_flags = FLAGS_Z;
    shadow_halted = 1'b0;

    // Directed part: field extremes, ADD, LDI, JSRR, illegal ops, keyboard latch.
    add_cmd(FUNC_READ, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    add_cmd(FUNC_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    add_cmd(FUNC_WRITE, 16'h3000, {OP_ADD, 3'd1, 3'd1, 1'b1, 5'h1F}, 1'b0, 8'h00);
    add_cmd(FUNC_WRITE, 16'h3001, {OP_RTI, 12'h000}, 1'b0, 8'd0);
    add_cmd(FUNC_EXEC, 16'd0, 16'd0, 1'b0, 8'd0);           // ADD imm -1
    add_cmd(FUNC_EXEC, 16'd0, 16'd0, 1'b1, 8'hAA);          // illegal, PC stays
    add_cmd(FUNC_WRITE, 16'h3001, {OP_RES, 12'hFFF}, 1'b0, 8'd0);
    add_cmd(FUNC_EXEC, 16'd0, 16'd0, 1'b0, 8'd0);
    add_cmd(FUNC_WRITE, 16'h3001, {OP_LDI, 3'd2, 9'h002}, 1'b0, 8'd0);
    add_cmd(FUNC_WRITE, 16'h3004, KBSR_ADDR, 1'b0, 8'd0);
    add_cmd(FUNC_EXEC, 16'd0, 16'd0, 1'b1, 8'h5A);          // LDI reads the key status
    add_cmd(FUNC_READ, KBDR_ADDR, 16'd0, 1'b0, 8'd0);
    add_cmd(FUNC_WRITE, 16'h3002, {OP_JSR, 1'b0, 2'd0, 3'd7, 6'd0}, 1'b0, 8'd0);
    add_cmd(FUNC_EXEC, 16'd0, 16'd0, 1'b0, 8'd0);           // JSRR R7 uses old R7
    for (i = 0; i < 16; i++) add_program(16'($urandom_range(0, 4)) + 16'h3000);
    add_cmd(FUNC_WRITE, 16'd0, {OP_TRAP, 4'd0, VEC_HALT}, 1'b0, 8'd0);
    add_cmd(FUNC_EXEC, 16'd0, 16'd0, 1'b0, 8'd0);
    add_cmd(FUNC_EXEC, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);   // executing while halted

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Long hold-off on the result side while the sender keeps going.
    repeat (65600) @(posedge clk);
    long_hold = 1'b1;
    repeat (200) @(posedge clk);
    long_hold = 1'b0;

    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    // The core is halted now; a fresh random load at its PC region cannot help,
    // so the random part leans on host traffic and halted execution afterwards,
    // unless the halt trap was skipped by a branch. Both paths are checked.
    for (i = 0; i < 600; i++) begin
      case ($urandom_range(0, 3))
        0: add_cmd(FUNC_WRITE, 16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
        1: add_cmd(FUNC_READ, 16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
        default: add_exec();
      endcase
    end
    wait (pending_cmds.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("[lc3_instruction_executor_core] OK");
    end else begin
      $display("[lc3_instruction_executor_core] ERROR");
    end
    $finish;
  end

endmodule
